// ===== rtl/snps_pkg.sv =====
`default_nettype none

package snps_pkg;

    // Sleep states, dense numbering.
    typedef enum logic [3:0] {
        ST_INIT       = 4'd0,
        ST_DOWN       = 4'd1,
        ST_UP         = 4'd2,
        ST_NOT_JOINED = 4'd3,
        ST_POLL_REQ   = 4'd4,
        ST_POLL_CHECK = 4'd5,
        ST_DATA_RX    = 4'd6,
        ST_NO_DATA    = 4'd7,
        ST_POLL_RETRY = 4'd8,
        ST_FAILED     = 4'd9
    } state_t;

    // Reschedule choices.
    typedef enum logic [1:0] {
        SCHED_NOW     = 2'd0,
        SCHED_SUSPEND = 2'd1,
        SCHED_LATER   = 2'd2,
        SCHED_NONE    = 2'd3
    } sched_t;

    // Event kinds.
    localparam logic [1:0] MODE_TICK    = 2'd0;
    localparam logic [1:0] MODE_POLL_CMPL = 2'd1;
    localparam logic [1:0] MODE_POWER_UP  = 2'd2;

    // Network phases.
    localparam logic [1:0] PHASE_STARTUP = 2'd0;
    localparam logic [1:0] PHASE_JOINING = 2'd1;
    localparam logic [1:0] PHASE_ACTIVE  = 2'd2;

    // Joining steps.
    localparam logic [2:0] JSTEP_RETRY_WAIT = 3'd1;
    localparam logic [2:0] JSTEP_KEY_CHECK  = 3'd2;
    localparam logic [2:0] JSTEP_LEAVE_CHECK = 3'd3;

    // Poll request outcomes.
    localparam logic [2:0] PRES_OK         = 3'd0;
    localparam logic [2:0] PRES_NOT_JOINED = 3'd1;
    localparam logic [2:0] PRES_FAIL       = 3'd2;
    localparam logic [2:0] PRES_OTHER      = 3'd5;

    // Poll completion outcomes.
    localparam logic [1:0] CRES_OK_DATA = 2'd0;
    localparam logic [1:0] CRES_NO_DATA = 2'd1;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SLOW_POLL_LIMIT = 3'd0,
        CFG_FAST_POLL_MS    = 3'd1,
        CFG_SLOW_POLL_MS    = 3'd2,
        CFG_HIBERNATE_MS    = 3'd3,
        CFG_REJOIN_RETRY_MS = 3'd4
    } cfg_idx_t;

    localparam int MS_W   = 24;
    localparam int NAP_W  = 8;

    localparam logic [NAP_W-1:0] SLOW_POLL_LIMIT_RST = 8'd4;
    localparam logic [MS_W-1:0]  FAST_POLL_MS_RST    = 24'd250;
    localparam logic [MS_W-1:0]  SLOW_POLL_MS_RST    = 24'd2000;
    localparam logic [MS_W-1:0]  HIBERNATE_MS_RST    = 24'd60000;
    localparam logic [MS_W-1:0]  REJOIN_RETRY_MS_RST = 24'd30000;

    typedef struct packed {
        logic [NAP_W-1:0] slow_poll_limit;
        logic [MS_W-1:0]  fast_poll_ms;
        logic [MS_W-1:0]  slow_poll_ms;
        logic [MS_W-1:0]  hibernate_ms;
        logic [MS_W-1:0]  rejoin_retry_ms;
    } cfg_t;

    typedef struct packed {
        logic [1:0] mode;
        logic [1:0] stack_phase;
        logic [2:0] joining_step;
        logic [2:0] poll_result;
        logic [1:0] completion_result;
        logic       nap_allowed;
        logic       hibernate_allowed;
    } event_t;

    typedef struct packed {
        state_t          sleep_state_now;
        logic            power_up_cmd;
        logic            power_down_cmd;
        logic            stack_tick_cmd;
        logic            poll_cmd;
        sched_t          schedule;
        logic [MS_W-1:0] delay_ms;
        logic            resume_task;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/snps_if.sv =====
`default_nettype none

// Event channel into the sequencer.
interface snps_evt_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [1:0] stack_phase;
    logic [2:0] joining_step;
    logic [2:0] poll_result;
    logic [1:0] completion_result;
    logic       nap_allowed;
    logic       hibernate_allowed;

    modport source (
        output valid, mode, stack_phase, joining_step, poll_result,
               completion_result, nap_allowed, hibernate_allowed,
        input  ready
    );
    modport sink (
        input  valid, mode, stack_phase, joining_step, poll_result,
               completion_result, nap_allowed, hibernate_allowed,
        output ready
    );
endinterface

// Result channel out of the sequencer.
interface snps_res_if;
    logic                       valid;
    logic                       ready;
    logic [3:0]                 sleep_state_now;
    logic                       power_up_cmd;
    logic                       power_down_cmd;
    logic                       stack_tick_cmd;
    logic                       poll_cmd;
    logic [1:0]                 schedule;
    logic [snps_pkg::MS_W-1:0]  delay_ms;
    logic                       resume_task;

    modport source (
        output valid, sleep_state_now, power_up_cmd, power_down_cmd,
               stack_tick_cmd, poll_cmd, schedule, delay_ms, resume_task,
        input  ready
    );
    modport sink (
        input  valid, sleep_state_now, power_up_cmd, power_down_cmd,
               stack_tick_cmd, poll_cmd, schedule, delay_ms, resume_task,
        output ready
    );
endinterface

// Configuration write channel.
interface snps_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [snps_pkg::CFG_IDX_W-1:0] index;
    logic [snps_pkg::MS_W-1:0]      data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/snps_step.sv =====
`default_nettype none

// Next-state and command logic for one event.
module snps_step (
    input  var snps_pkg::state_t                 state,
    input  var logic [snps_pkg::NAP_W-1:0]       nap_count,
    input  var snps_pkg::cfg_t                   cfg,
    input  var snps_pkg::event_t                 evt,
    output snps_pkg::state_t                     state_next,
    output logic [snps_pkg::NAP_W-1:0]           nap_count_next,
    output snps_pkg::result_t                    result
);

    logic                      under_limit;
    logic [snps_pkg::MS_W-1:0] long_ms;
    snps_pkg::state_t          nxt;
    snps_pkg::sched_t          sched;
    logic [snps_pkg::MS_W-1:0] delay;
    logic                      up;
    logic                      poll;
    logic                      resume;

    assign under_limit = nap_count < cfg.slow_poll_limit;
    assign long_ms = (state == snps_pkg::ST_NO_DATA) ? cfg.hibernate_ms
                                                     : cfg.rejoin_retry_ms;

    always_comb
    begin
        nxt            = state;
        nap_count_next = nap_count;
        sched          = snps_pkg::SCHED_NONE;
        delay          = '0;
        up             = 1'b0;
        poll           = 1'b0;
        resume         = 1'b0;

        if (evt.mode == snps_pkg::MODE_TICK)
        begin
            sched = snps_pkg::SCHED_NOW;
            case (state)
                snps_pkg::ST_INIT:
                begin
                    if (evt.stack_phase != snps_pkg::PHASE_STARTUP)
                    begin
                        nxt = snps_pkg::ST_UP;
                    end
                end
                snps_pkg::ST_DOWN:
                begin
                    up  = 1'b1;
                    nxt = snps_pkg::ST_UP;
                end
                snps_pkg::ST_UP:
                begin
                    nxt = (evt.stack_phase == snps_pkg::PHASE_ACTIVE)
                          ? snps_pkg::ST_POLL_REQ : snps_pkg::ST_NOT_JOINED;
                end
                snps_pkg::ST_NOT_JOINED:
                begin
                    if (evt.stack_phase == snps_pkg::PHASE_JOINING &&
                        evt.joining_step <= snps_pkg::JSTEP_RETRY_WAIT)
                    begin
                        if (evt.hibernate_allowed)
                        begin
                            nxt   = snps_pkg::ST_DOWN;
                            sched = snps_pkg::SCHED_SUSPEND;
                        end
                        else
                        begin
                            nxt = snps_pkg::ST_UP;
                        end
                    end
                    else if (evt.stack_phase == snps_pkg::PHASE_JOINING &&
                             (evt.joining_step == snps_pkg::JSTEP_KEY_CHECK ||
                              evt.joining_step == snps_pkg::JSTEP_LEAVE_CHECK))
                    begin
                        nap_count_next = '0;
                        nxt            = snps_pkg::ST_POLL_REQ;
                    end
                    else
                    begin
                        nxt = snps_pkg::ST_UP;
                    end
                end
                snps_pkg::ST_POLL_REQ:
                begin
                    poll = 1'b1;
                    // Queue full and allocation failure stay here for a retry.
                    if (evt.poll_result == snps_pkg::PRES_OK)
                    begin
                        nxt = snps_pkg::ST_POLL_CHECK;
                    end
                    else if (evt.poll_result == snps_pkg::PRES_NOT_JOINED)
                    begin
                        nxt = snps_pkg::ST_NOT_JOINED;
                    end
                    else if (evt.poll_result == snps_pkg::PRES_FAIL)
                    begin
                        nxt = snps_pkg::ST_POLL_RETRY;
                    end
                    else if (evt.poll_result >= snps_pkg::PRES_OTHER)
                    begin
                        nxt = snps_pkg::ST_FAILED;
                    end
                end
                snps_pkg::ST_DATA_RX:
                begin
                    if (evt.nap_allowed)
                    begin
                        nap_count_next = '0;
                        nxt            = snps_pkg::ST_DOWN;
                        sched          = snps_pkg::SCHED_LATER;
                        delay          = cfg.fast_poll_ms;
                    end
                end
                snps_pkg::ST_NO_DATA, snps_pkg::ST_POLL_RETRY:
                begin
                    if (under_limit)
                    begin
                        if (evt.nap_allowed)
                        begin
                            nap_count_next = nap_count + 1'b1;
                            nxt            = snps_pkg::ST_DOWN;
                            sched          = snps_pkg::SCHED_LATER;
                            delay          = cfg.slow_poll_ms;
                        end
                    end
                    else if (evt.hibernate_allowed)
                    begin
                        nap_count_next = '0;
                        nxt            = snps_pkg::ST_DOWN;
                        sched          = snps_pkg::SCHED_LATER;
                        delay          = long_ms;
                    end
                end
                default:
                begin
                    // Poll check waits for completion; failed is terminal.
                end
            endcase
        end
        else if (evt.mode == snps_pkg::MODE_POLL_CMPL)
        begin
            if (state == snps_pkg::ST_POLL_CHECK)
            begin
                if (evt.completion_result == snps_pkg::CRES_OK_DATA)
                begin
                    nxt = snps_pkg::ST_DATA_RX;
                end
                else if (evt.completion_result == snps_pkg::CRES_NO_DATA)
                begin
                    nxt = snps_pkg::ST_NO_DATA;
                end
                else
                begin
                    nxt = snps_pkg::ST_POLL_RETRY;
                end
            end
        end
        else if (evt.mode == snps_pkg::MODE_POWER_UP)
        begin
            if (state == snps_pkg::ST_DOWN)
            begin
                up     = 1'b1;
                resume = 1'b1;
                nxt    = snps_pkg::ST_UP;
            end
        end
    end

    assign state_next = nxt;

    always_comb
    begin
        result.sleep_state_now = nxt;
        result.power_up_cmd    = up;
        result.power_down_cmd  = (evt.mode == snps_pkg::MODE_TICK) &&
                                 (nxt == snps_pkg::ST_DOWN);
        result.stack_tick_cmd  = (evt.mode == snps_pkg::MODE_TICK) &&
                                 (nxt != snps_pkg::ST_DOWN);
        result.poll_cmd        = poll;
        result.schedule        = sched;
        result.delay_ms        = delay;
        result.resume_task     = resume;
    end

endmodule

`default_nettype wire

// ===== rtl/sleepy_node_power_sequencer.sv =====
// Channel   Direction  Handshake    Payload
// evt       in         valid/ready  mode, stack_phase, joining_step, poll_result,
//                                   completion_result, nap_allowed, hibernate_allowed
// res       out        valid/ready  sleep_state_now, power/tick/poll commands,
//                                   schedule, delay_ms, resume_task
// cfg       in         valid/ready  index, data (24 bits, truncated per register)
//
// An event is evaluated against the state registers in the cycle it is accepted,
// and its result appears in the output register in the next cycle.
// A new event can be accepted every cycle while the output register is empty or
// drained; the state feedback through the single step of next-state logic sets that rate.
// Reset clears the sleep state to init, the nap counter to zero and loads the
// register defaults. When the result is not taken, the event channel stalls
// until the output register frees; configuration writes are always accepted.
`default_nettype none

module sleepy_node_power_sequencer (
    input  var logic    clk,
    input  var logic    rst_n,
    snps_evt_if.sink    evt,
    snps_res_if.source  res,
    snps_cfg_if.sink    cfg
);

    // Sleep state and nap counter carried from event to event.
    snps_pkg::state_t               state_reg;
    logic [snps_pkg::NAP_W-1:0]     nap_count_reg;
    snps_pkg::cfg_t                 cfg_reg;

    // Output register holding one finished result.
    snps_pkg::result_t              res_reg;
    logic                           res_valid_reg;

    snps_pkg::event_t               evt_bus;
    snps_pkg::state_t               state_next;
    logic [snps_pkg::NAP_W-1:0]     nap_count_next;
    snps_pkg::result_t              res_next;
    logic                           evt_accept;

    // The event side is ready whenever the output register is empty or is being
    // drained in this same cycle, so back-to-back events flow without a bubble.
    assign evt.ready  = !res_valid_reg || res.ready;
    assign evt_accept = evt.valid && evt.ready;

    assign cfg.ready = 1'b1;

    assign evt_bus.mode              = evt.mode;
    assign evt_bus.stack_phase       = evt.stack_phase;
    assign evt_bus.joining_step      = evt.joining_step;
    assign evt_bus.poll_result       = evt.poll_result;
    assign evt_bus.completion_result = evt.completion_result;
    assign evt_bus.nap_allowed       = evt.nap_allowed;
    assign evt_bus.hibernate_allowed = evt.hibernate_allowed;

    snps_step u_step (
        .state          (state_reg),
        .nap_count      (nap_count_reg),
        .cfg            (cfg_reg),
        .evt            (evt_bus),
        .state_next     (state_next),
        .nap_count_next (nap_count_next),
        .result         (res_next)
    );

    // State and output-valid control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= snps_pkg::ST_INIT;
            nap_count_reg <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (evt_accept)
            begin
                state_reg     <= state_next;
                nap_count_reg <= nap_count_next;
                res_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload only changes when a new event is accepted.
    always_ff @(posedge clk)
    begin
        if (evt_accept)
        begin
            res_reg <= res_next;
        end
    end

    // Configuration registers; a write to an unknown index is dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.slow_poll_limit <= snps_pkg::SLOW_POLL_LIMIT_RST;
            cfg_reg.fast_poll_ms    <= snps_pkg::FAST_POLL_MS_RST;
            cfg_reg.slow_poll_ms    <= snps_pkg::SLOW_POLL_MS_RST;
            cfg_reg.hibernate_ms    <= snps_pkg::HIBERNATE_MS_RST;
            cfg_reg.rejoin_retry_ms <= snps_pkg::REJOIN_RETRY_MS_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                snps_pkg::CFG_SLOW_POLL_LIMIT:
                    cfg_reg.slow_poll_limit <= cfg.data[snps_pkg::NAP_W-1:0];
                snps_pkg::CFG_FAST_POLL_MS:
                    cfg_reg.fast_poll_ms    <= cfg.data;
                snps_pkg::CFG_SLOW_POLL_MS:
                    cfg_reg.slow_poll_ms    <= cfg.data;
                snps_pkg::CFG_HIBERNATE_MS:
                    cfg_reg.hibernate_ms    <= cfg.data;
                snps_pkg::CFG_REJOIN_RETRY_MS:
                    cfg_reg.rejoin_retry_ms <= cfg.data;
                default:
                begin
                end
            endcase
        end
    end

    assign res.valid           = res_valid_reg;
    assign res.sleep_state_now = res_reg.sleep_state_now;
    assign res.power_up_cmd    = res_reg.power_up_cmd;
    assign res.power_down_cmd  = res_reg.power_down_cmd;
    assign res.stack_tick_cmd  = res_reg.stack_tick_cmd;
    assign res.poll_cmd        = res_reg.poll_cmd;
    assign res.schedule        = res_reg.schedule;
    assign res.delay_ms        = res_reg.delay_ms;
    assign res.resume_task     = res_reg.resume_task;

endmodule

`default_nettype wire

// ===== rtl/snps_checker.sv =====
`default_nettype none

module snps_checker (
    input var logic                          clk,
    input var logic                          rst_n,
    input var logic                          res_valid,
    input var logic                          res_ready,
    input var logic [3:0]                    sleep_state_now,
    input var logic                          power_up_cmd,
    input var logic                          power_down_cmd,
    input var logic                          stack_tick_cmd,
    input var logic [1:0]                    schedule,
    input var logic [snps_pkg::MS_W-1:0]     delay_ms,
    input var logic                          resume_task
);

    // A stalled result holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(sleep_state_now) &&
        $stable(schedule) && $stable(delay_ms))
        else $error("stalled result changed");

    // A delay is only reported together with a deferred reschedule.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && schedule != snps_pkg::SCHED_LATER |-> delay_ms == '0)
        else $error("delay without run-later schedule");

    // Power down goes with the powered-down state and never with a stack tick.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && power_down_cmd |->
        sleep_state_now == snps_pkg::ST_DOWN && !stack_tick_cmd && !power_up_cmd)
        else $error("power down inconsistent");

    // Resuming comes only from a power-up request that reached powered up.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && resume_task |->
        power_up_cmd && sleep_state_now == snps_pkg::ST_UP &&
        schedule == snps_pkg::SCHED_NONE && !stack_tick_cmd)
        else $error("resume inconsistent");

endmodule

bind sleepy_node_power_sequencer snps_checker u_snps_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .res_valid       (res.valid),
    .res_ready       (res.ready),
    .sleep_state_now (res.sleep_state_now),
    .power_up_cmd    (res.power_up_cmd),
    .power_down_cmd  (res.power_down_cmd),
    .stack_tick_cmd  (res.stack_tick_cmd),
    .schedule        (res.schedule),
    .delay_ms        (res.delay_ms),
    .resume_task     (res.resume_task)
);

`default_nettype wire
